[hdl/mmr_pkg.sv]
// Shared types, constants and the helper function of the minimap 2x2 reducer.
package mmr_pkg;

    // Configuration port layout and register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_ENABLE  = 2'd2;

    // Register reset values.
    localparam int SOURCE_WIDTH_DEFAULT  = 100;
    localparam int SOURCE_HEIGHT_DEFAULT = 2048;

    // Pixel value constants.
    localparam logic [7:0]  GRAY_BLANK   = 8'd255;
    localparam logic [7:0]  GRAY_CAP     = 8'd210;
    localparam logic [31:0] COLOR_NONE   = 32'hffff_ffff;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

    // Reciprocal of three for a 12-bit dividend: floor(x * 2731 / 8192) == x / 3.
    localparam logic [11:0] DIV3_RECIP = 12'd2731;
    localparam int          DIV3_SHIFT = 13;

    // Depth of the queue between the front and the back end.
    localparam int PAIR_QUEUE_DEPTH = 4;

    // One configuration write transaction.
    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

    // Gray partial: sum, pixel count and darkest value.
    typedef struct packed {
        logic [9:0] sum;
        logic [2:0] count;
        logic [7:0] darkest;
    } gray_acc_t;

    // Colour partial: channel sums and count of coloured pixels.
    typedef struct packed {
        logic [9:0] r;
        logic [9:0] g;
        logic [9:0] b;
        logic [2:0] count;
    } color_acc_t;

    typedef struct packed {
        gray_acc_t  gray;
        color_acc_t color;
    } pair_acc_t;

    // What the back end does with a finished horizontal pair.
    typedef enum logic [1:0] {
        PAIR_STORE,   // upper row of a block: park it in the line store
        PAIR_MERGE,   // lower row: combine with the stored upper pair and emit
        PAIR_ALONE    // single-row block at an odd bottom edge: emit as it is
    } pair_kind_t;

    typedef struct packed {
        pair_kind_t kind;
        logic       last;
        pair_acc_t  acc;
    } pair_rec_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_MERGE,
        BACK_DIVIDE,
        BACK_FINISH
    } back_state_t;

    // Divides a 12-bit value by a pixel count of one to four.
    function automatic logic [11:0] div_small(input logic [11:0] x, input logic [2:0] c);
        logic [23:0] prod;
        logic [11:0] q;
        prod = 24'(x) * 24'(DIV3_RECIP);
        unique case (c)
            3'd1:    q = x;
            3'd2:    q = x >> 1;
            3'd3:    q = 12'(prod >> DIV3_SHIFT);
            3'd4:    q = x >> 2;
            default: q = x;
        endcase
        return q;
    endfunction

endpackage

[hdl/mmr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mmr_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 64,
        parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic             clk,
        input  logic             wr_en,
        input  logic [AW-1:0]    wr_addr,
        input  logic [WIDTH-1:0] wr_data,
        input  logic             rd_en,
        input  logic [AW-1:0]    rd_addr,
        output logic [WIDTH-1:0] rd_data
    );

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/mmr_fifo.sv]
// Short register queue that decouples the front end from the back end.
module mmr_fifo
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 4
    )
    (
        input  logic             clk,
        input  logic             rst_n,
        input  logic             push,
        input  logic [WIDTH-1:0] push_data,
        output logic             full,
        input  logic             pop,
        output logic [WIDTH-1:0] head,
        output logic             empty
    );

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW:0]      wr_ptr_reg;
    logic [PW:0]      rd_ptr_reg;

    // Full when the pointers differ only in the wrap bit.
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[PW] != rd_ptr_reg[PW]) &&
                   (wr_ptr_reg[PW-1:0] == rd_ptr_reg[PW-1:0]);
    assign head  = slot_reg[rd_ptr_reg[PW-1:0]];

    // Pointer update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg[PW-1:0]] <= push_data;
        end
    end

endmodule

[hdl/mmr_front.sv]
// Front end: takes pixels, tracks the raster position and builds horizontal pairs.
module mmr_front
    import mmr_pkg::*;
    #(
        parameter int MAX_WIDTH  = 128,
        parameter int MAX_HEIGHT = 4096,
        parameter int SW         = 6
    )
    (
        input  logic             clk,
        input  logic             rst_n,
        input  cfg_write_t       cfg,
        input  logic             in_valid,
        output logic             in_ready,
        input  logic [7:0]       gray_in,
        input  logic [31:0]      color_in,
        output logic             push,
        output pair_rec_t        push_rec,
        output logic [SW-1:0]    push_slot,
        input  logic             queue_full
    );

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int WIDTH_RESET  =
        (SOURCE_WIDTH_DEFAULT > MAX_WIDTH) ? MAX_WIDTH : SOURCE_WIDTH_DEFAULT;
    localparam int HEIGHT_RESET =
        (SOURCE_HEIGHT_DEFAULT > MAX_HEIGHT) ? MAX_HEIGHT : SOURCE_HEIGHT_DEFAULT;

    logic [WW-1:0] width_reg,  width_next;
    logic [HW-1:0] height_reg, height_next;
    logic [CW-1:0] col_reg,    col_next;
    logic [RW-1:0] row_reg,    row_next;
    pair_acc_t     pair_reg,   pair_next;

    logic          accept;
    logic          last_col;
    logic          last_row;
    logic          has_color;
    pair_acc_t     pair_base;
    logic [7:0]    wv;
    logic [12:0]   hv;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && !queue_full;
    assign last_col  = (WW'(col_reg) + WW'(1)) >= width_reg;
    assign last_row  = (HW'(row_reg) + HW'(1)) >= height_reg;
    assign has_color = (color_in != COLOR_NONE);
    assign wv        = cfg.data[7:0];
    assign hv        = cfg.data[12:0];

    // Pair accumulation: an even column starts a fresh pair.
    always_comb
    begin
        pair_base = pair_reg;
        if (!col_reg[0])
        begin
            pair_base = '0;
            pair_base.gray.darkest = GRAY_BLANK;
        end
        pair_next = pair_base;
        pair_next.gray.sum   = pair_base.gray.sum + 10'(gray_in);
        pair_next.gray.count = pair_base.gray.count + 3'd1;
        if (gray_in < pair_base.gray.darkest)
        begin
            pair_next.gray.darkest = gray_in;
        end
        if (has_color)
        begin
            pair_next.color.r     = pair_base.color.r + 10'(color_in[23:16]);
            pair_next.color.g     = pair_base.color.g + 10'(color_in[15:8]);
            pair_next.color.b     = pair_base.color.b + 10'(color_in[7:0]);
            pair_next.color.count = pair_base.color.count + 3'd1;
        end
    end

    // Classification of a finished pair for the back end.
    always_comb
    begin
        push               = accept && (col_reg[0] || last_col);
        push_rec.acc       = pair_next;
        push_rec.last      = last_col && last_row;
        push_slot          = SW'(col_reg >> 1);
        if (row_reg[0])
        begin
            push_rec.kind = PAIR_MERGE;
        end
        else if (!last_row)
        begin
            push_rec.kind = PAIR_STORE;
        end
        else
        begin
            push_rec.kind = PAIR_ALONE;
        end
    end

    // Register writes, frame restart and raster position.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg.valid &&
            (cfg.index == CFG_SOURCE_WIDTH || cfg.index == CFG_SOURCE_HEIGHT))
        begin
            col_next = '0;
            row_next = '0;
            if (cfg.index == CFG_SOURCE_WIDTH)
            begin
                if (wv == '0)
                    width_next = WW'(1);
                else if (32'(wv) > 32'(MAX_WIDTH))
                    width_next = WW'(MAX_WIDTH);
                else
                    width_next = WW'(wv);
            end
            else
            begin
                if (hv == '0)
                    height_next = HW'(1);
                else if (32'(hv) > 32'(MAX_HEIGHT))
                    height_next = HW'(MAX_HEIGHT);
                else
                    height_next = HW'(hv);
            end
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : RW'(row_reg + 1'b1);
            end
            else
            begin
                col_next = CW'(col_reg + 1'b1);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(WIDTH_RESET);
            height_reg <= HW'(HEIGHT_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
            pair_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            if (cfg.valid &&
                (cfg.index == CFG_SOURCE_WIDTH || cfg.index == CFG_SOURCE_HEIGHT))
            begin
                pair_reg <= '0;
            end
            else if (accept)
            begin
                pair_reg <= pair_next;
            end
        end
    end

endmodule

[hdl/mmr_back.sv]
// Back end: parks upper pairs in the line store, merges lower pairs and forms results.
module mmr_back
    import mmr_pkg::*;
    #(
        parameter int SW          = 6,
        parameter int STORE_DEPTH = 64
    )
    (
        input  logic          clk,
        input  logic          rst_n,
        input  cfg_write_t    cfg,
        input  logic          queue_empty,
        input  pair_rec_t     head_rec,
        input  logic [SW-1:0] head_slot,
        output logic          pop,
        output logic          out_valid,
        input  logic          out_ready,
        output logic [7:0]    gray_out,
        output logic [31:0]   color_out,
        output logic          last_pixel
    );

    back_state_t state_reg, state_next;
    logic        color_en_reg, color_en_next;
    pair_rec_t   rec_reg,   rec_next;
    pair_acc_t   acc_reg,   acc_next;
    logic [11:0] gq_reg,    gq_next;
    logic [7:0]  rq_reg,    rq_next;
    logic [7:0]  gcq_reg,   gcq_next;
    logic [7:0]  bq_reg,    bq_next;
    logic        ov_reg,    ov_next;
    logic [7:0]  og_reg,    og_next;
    logic [31:0] oc_reg,    oc_next;
    logic        ol_reg,    ol_next;

    logic        ram_wr_en;
    logic        ram_rd_en;
    logic [$bits(pair_acc_t)-1:0] ram_rd_data;
    pair_acc_t   stored;
    logic        merge;
    logic        out_free;
    logic [11:0] triple;
    logic [11:0] gray_mix;

    assign stored    = pair_acc_t'(ram_rd_data);
    assign merge     = (rec_reg.kind == PAIR_MERGE);
    assign out_free  = !ov_reg || out_ready;
    assign triple    = 12'(acc_reg.gray.sum) * 12'd3;
    assign gray_mix  = (gq_reg + 12'(acc_reg.gray.darkest)) >> 2;
    assign out_valid = ov_reg;
    assign gray_out  = og_reg;
    assign color_out = oc_reg;
    assign last_pixel = ol_reg;

    // Line store of upper-row pair partials, one entry per output column.
    mmr_ram
        #(
            .WIDTH ($bits(pair_acc_t)),
            .DEPTH (STORE_DEPTH),
            .AW    (SW)
        )
        u_line_store
        (
            .clk     (clk),
            .wr_en   (ram_wr_en),
            .wr_addr (head_slot),
            .wr_data (head_rec.acc),
            .rd_en   (ram_rd_en),
            .rd_addr (head_slot),
            .rd_data (ram_rd_data)
        );

    // Sequencer: park an upper pair, or read the store, merge, divide, then emit.
    always_comb
    begin
        state_next    = state_reg;
        color_en_next = color_en_reg;
        rec_next      = rec_reg;
        acc_next      = acc_reg;
        gq_next       = gq_reg;
        rq_next       = rq_reg;
        gcq_next      = gcq_reg;
        bq_next       = bq_reg;
        ov_next       = ov_reg && !out_ready;
        og_next       = og_reg;
        oc_next       = oc_reg;
        ol_next       = ol_reg;
        pop           = 1'b0;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;

        if (cfg.valid && cfg.index == CFG_COLOR_ENABLE)
        begin
            color_en_next = cfg.data[0];
        end

        unique case (state_reg)
            BACK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop = 1'b1;
                    if (head_rec.kind == PAIR_STORE)
                    begin
                        ram_wr_en = 1'b1;
                    end
                    else
                    begin
                        ram_rd_en  = 1'b1;
                        rec_next   = head_rec;
                        state_next = BACK_MERGE;
                    end
                end
            end
            BACK_MERGE:
            begin
                acc_next = rec_reg.acc;
                if (merge)
                begin
                    acc_next.gray.sum    = rec_reg.acc.gray.sum + stored.gray.sum;
                    acc_next.gray.count  = rec_reg.acc.gray.count + stored.gray.count;
                    if (stored.gray.count != '0 &&
                        stored.gray.darkest < rec_reg.acc.gray.darkest)
                    begin
                        acc_next.gray.darkest = stored.gray.darkest;
                    end
                    acc_next.color.r     = rec_reg.acc.color.r + stored.color.r;
                    acc_next.color.g     = rec_reg.acc.color.g + stored.color.g;
                    acc_next.color.b     = rec_reg.acc.color.b + stored.color.b;
                    acc_next.color.count = rec_reg.acc.color.count + stored.color.count;
                end
                state_next = BACK_DIVIDE;
            end
            BACK_DIVIDE:
            begin
                gq_next  = div_small(triple, acc_reg.gray.count);
                rq_next  = 8'(div_small(12'(acc_reg.color.r), acc_reg.color.count));
                gcq_next = 8'(div_small(12'(acc_reg.color.g), acc_reg.color.count));
                bq_next  = 8'(div_small(12'(acc_reg.color.b), acc_reg.color.count));
                state_next = BACK_FINISH;
            end
            BACK_FINISH:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ol_next = rec_reg.last;
                    if (acc_reg.gray.darkest < GRAY_BLANK && acc_reg.gray.count != '0)
                    begin
                        og_next = (gray_mix < 12'(GRAY_CAP)) ? gray_mix[7:0] : GRAY_CAP;
                    end
                    else
                    begin
                        og_next = GRAY_BLANK;
                    end
                    if (color_en_reg && acc_reg.color.count != '0)
                    begin
                        oc_next = {ALPHA_OPAQUE, rq_reg, gcq_reg, bq_reg};
                    end
                    else
                    begin
                        oc_next = COLOR_NONE;
                    end
                    state_next = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BACK_IDLE;
            color_en_reg <= 1'b1;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            color_en_reg <= color_en_next;
            ov_reg       <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        acc_reg <= acc_next;
        gq_reg  <= gq_next;
        rq_reg  <= rq_next;
        gcq_reg <= gcq_next;
        bq_reg  <= bq_next;
        og_reg  <= og_next;
        oc_reg  <= oc_next;
        ol_reg  <= ol_next;
    end

endmodule

[hdl/minimap_two_by_two_reducer.sv]
// Top level of the minimap 2x2 reducer: stream ports, configuration port and the two ends.
//
// The block takes one level of a minimap image in raster order and gives the
// half-size level, one result per 2x2 block (clipped at odd edges) in raster
// order, with tlast on the final pixel of the reduced level. The front end
// accepts one pixel per cycle while its four-entry pair queue has room. The
// back end parks each upper-row pair in the line store as it takes it from
// the queue and takes each pair of a lower or single bottom row through store
// read, merge, divide and output, so upper rows run at one pixel per cycle
// while the queue has room and lower rows are set by the result sequencer,
// which takes no new pair until it has emitted the last. There is no clearing
// pass after reset: the line store is always written before a merge uses it.
// Writing source_width or source_height restarts the frame.
module minimap_two_by_two_reducer
    import mmr_pkg::*;
    #(
        parameter int MAX_WIDTH  = 128,
        parameter int MAX_HEIGHT = 4096
    )
    (
        input  logic                   clk,
        input  logic                   rst_n,
        // Input pixels. tdata: gray_in [7:0], color_in [39:8].
        input  logic                   s_tvalid,
        output logic                   s_tready,
        input  logic [39:0]            s_tdata,
        // Reduced pixels. tdata: gray_out [7:0], color_out [39:8]; tlast: last_pixel.
        output logic                   m_tvalid,
        input  logic                   m_tready,
        output logic [39:0]            m_tdata,
        output logic                   m_tlast,
        // Configuration writes.
        input  logic                   cfg_valid,
        output logic                   cfg_ready,
        input  logic [CFG_INDEX_W-1:0] cfg_index,
        input  logic [CFG_DATA_W-1:0]  cfg_data
    );

    localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int SW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int QW          = $bits(pair_rec_t) + SW;

    cfg_write_t    cfg;
    logic          push;
    pair_rec_t     push_rec;
    logic [SW-1:0] push_slot;
    logic          queue_full;
    logic          queue_empty;
    logic          pop;
    logic [QW-1:0] head;
    logic [7:0]    gray_out;
    logic [31:0]   color_out;

    // Configuration transactions are always taken.
    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign m_tdata = {color_out, gray_out};

    // Front end: position tracking and pair building.
    mmr_front
        #(
            .MAX_WIDTH  (MAX_WIDTH),
            .MAX_HEIGHT (MAX_HEIGHT),
            .SW         (SW)
        )
        u_front
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cfg        (cfg),
            .in_valid   (s_tvalid),
            .in_ready   (s_tready),
            .gray_in    (s_tdata[7:0]),
            .color_in   (s_tdata[39:8]),
            .push       (push),
            .push_rec   (push_rec),
            .push_slot  (push_slot),
            .queue_full (queue_full)
        );

    // Pair queue between the two ends.
    mmr_fifo
        #(
            .WIDTH (QW),
            .DEPTH (PAIR_QUEUE_DEPTH)
        )
        u_queue
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .push      (push),
            .push_data ({push_slot, push_rec}),
            .full      (queue_full),
            .pop       (pop),
            .head      (head),
            .empty     (queue_empty)
        );

    // Back end: line store, merge and result formation.
    mmr_back
        #(
            .SW          (SW),
            .STORE_DEPTH (STORE_DEPTH)
        )
        u_back
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .cfg         (cfg),
            .queue_empty (queue_empty),
            .head_rec    (pair_rec_t'(head[$bits(pair_rec_t)-1:0])),
            .head_slot   (head[QW-1:$bits(pair_rec_t)]),
            .pop         (pop),
            .out_valid   (m_tvalid),
            .out_ready   (m_tready),
            .gray_out    (gray_out),
            .color_out   (color_out),
            .last_pixel  (m_tlast)
        );

endmodule

[tb/tb_minimap_two_by_two_reducer.sv]
// Self-checking testbench for the minimap 2x2 reducer.
module tb_minimap_two_by_two_reducer
    import mmr_pkg::*;
    ();

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles the block may still be busy after the last result: pair queue plus back end.
    localparam int DRAIN_CYCLES  = 40;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int STORE_SLOTS   = 64;
    localparam int WIDTH_CEILING = 128;
    localparam int HEIGHT_CEILING = 4096;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // One source pixel, laid out as on s_tdata.
    typedef struct packed {
        logic [31:0] colour;
        logic [7:0]  gray;
    } pixel_t;

    // One reduced pixel.
    typedef struct {
        logic [7:0]  gray;
        logic [31:0] colour;
        logic        last;
    } reduced_t;

    typedef struct {
        logic [9:0] sum;
        logic [2:0] count;
        logic [7:0] darkest;
    } gray_part_t;

    typedef struct {
        logic [9:0] r;
        logic [9:0] g;
        logic [9:0] b;
        logic [2:0] count;
    } colour_part_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [39:0]            s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [39:0]            m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Model state of the block.
    gray_part_t   upper_gray [STORE_SLOTS];
    colour_part_t upper_colour [STORE_SLOTS];
    gray_part_t   pair_gray;
    colour_part_t pair_colour;
    logic [6:0]   col_pos;
    logic [11:0]  row_pos;
    logic [7:0]   level_width;
    logic [12:0]  level_height;
    logic         colour_on;

    pixel_t   pixel_queue [$];
    reduced_t reduced_expected [$];
    pixel_t   offered_pixel;
    int       failures = 0;
    int       cycle_count = 0;
    int       sender_idle_pct = 0;
    int       receiver_idle_pct = 0;
    int       hold_requests = 0;
    int       hold_served = 0;
    int       hold_left = 0;

    minimap_two_by_two_reducer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Appends one pixel to the tail of the pending queue.
    function automatic void add_pixel(input pixel_t px);
        pixel_queue.insert(pixel_queue.size(), px);
    endfunction

    // Frame restart after a size write: positions and pair partials cleared.
    function automatic void restart_level();
        col_pos = '0;
        row_pos = '0;
        pair_gray = '{default: '0};
        pair_colour = '{default: '0};
    endfunction

    // Applies one register write to the model, saturating the sizes.
    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        int v;
        if (idx == CFG_SOURCE_WIDTH)
        begin
            v = int'(value[7:0]);
            level_width = (v < 1) ? 8'd1 : (v > WIDTH_CEILING) ? 8'(WIDTH_CEILING) : 8'(v);
            restart_level();
        end
        else if (idx == CFG_SOURCE_HEIGHT)
        begin
            v = int'(value);
            level_height = (v < 1) ? 13'd1 :
                           (v > HEIGHT_CEILING) ? 13'(HEIGHT_CEILING) : 13'(v);
            restart_level();
        end
        else if (idx == CFG_COLOR_ENABLE)
        begin
            colour_on = value[0];
        end
    endfunction

    // Takes one source pixel into the model and queues the reduced pixel it completes.
    function automatic void reduce_pixel(input pixel_t px);
        logic       last_col;
        logic       last_row;
        logic [5:0] slot;
        int         sum, count, darkest, r, g, b, ccount, v;
        reduced_t   res;
        last_col = (int'(col_pos) + 1 >= int'(level_width));
        last_row = (int'(row_pos) + 1 >= int'(level_height));
        if (!col_pos[0])
        begin
            pair_gray = '{sum: '0, count: '0, darkest: GRAY_BLANK};
            pair_colour = '{default: '0};
        end
        pair_gray.sum += 10'(px.gray);
        pair_gray.count += 3'd1;
        if (px.gray < pair_gray.darkest)
            pair_gray.darkest = px.gray;
        if (px.colour != COLOR_NONE)
        begin
            pair_colour.r += 10'(px.colour[23:16]);
            pair_colour.g += 10'(px.colour[15:8]);
            pair_colour.b += 10'(px.colour[7:0]);
            pair_colour.count += 3'd1;
        end

        if (col_pos[0] || last_col)
        begin
            slot = col_pos[6:1];
            if (!row_pos[0] && !last_row)
            begin
                upper_gray[slot] = pair_gray;
                upper_colour[slot] = pair_colour;
            end
            else
            begin
                sum = pair_gray.sum;
                count = pair_gray.count;
                darkest = pair_gray.darkest;
                r = pair_colour.r;
                g = pair_colour.g;
                b = pair_colour.b;
                ccount = pair_colour.count;
                // Lower row of a block: fold in the upper pair from the line store.
                if (row_pos[0])
                begin
                    sum += upper_gray[slot].sum;
                    count += upper_gray[slot].count;
                    if (upper_gray[slot].count != 0 && upper_gray[slot].darkest < darkest)
                        darkest = upper_gray[slot].darkest;
                    r += upper_colour[slot].r;
                    g += upper_colour[slot].g;
                    b += upper_colour[slot].b;
                    ccount += upper_colour[slot].count;
                end
                if (darkest < int'(GRAY_BLANK) && count != 0)
                begin
                    v = (3 * sum / count + darkest) / 4;
                    res.gray = (v < int'(GRAY_CAP)) ? 8'(v) : GRAY_CAP;
                end
                else
                begin
                    res.gray = GRAY_BLANK;
                end
                if (colour_on && ccount != 0)
                    res.colour = {ALPHA_OPAQUE, 8'(r / ccount), 8'(g / ccount),
                                  8'(b / ccount)};
                else
                    res.colour = COLOR_NONE;
                res.last = last_col && last_row;
                reduced_expected.insert(reduced_expected.size(), res);
            end
        end

        if (last_col)
        begin
            col_pos = '0;
            row_pos = last_row ? 12'd0 : row_pos + 12'd1;
        end
        else
        begin
            col_pos = col_pos + 7'd1;
        end
    endfunction

    // Random pixel biased towards blank and uncoloured values.
    function automatic pixel_t random_pixel();
        pixel_t px;
        case ($urandom_range(0, 9))
            0, 1, 2: px.gray = GRAY_BLANK;
            3:       px.gray = 8'd0;
            4:       px.gray = 8'($urandom_range(200, 255));
            default: px.gray = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: px.colour = COLOR_NONE;
            3:       px.colour = 32'h0;
            default: px.colour = $urandom();
        endcase
        return px;
    endfunction

    // Source side: offers queued pixels, models each accepted transaction.
    always @(posedge clk)
    begin : pixel_driver
        logic offering;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            offering = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                reduce_pixel(offered_pixel);
                offering = 1'b0;
            end
            if (!offering && pixel_queue.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct)
            begin
                offered_pixel = pixel_queue.pop_front();
                offering = 1'b1;
                s_tdata <= offered_pixel;
            end
            s_tvalid <= offering;
        end
    end

    // Long receiver hold-off, started on request from the stimulus.
    always @(posedge clk)
    begin : hold_off_counter
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != hold_served)
        begin
            hold_left <= HOLD_OFF_LEN;
            hold_served <= hold_served + 1;
        end
    end

    // Result side: compares each accepted transaction with the oldest expectation.
    always @(posedge clk)
    begin : reduced_monitor
        reduced_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (reduced_expected.size() == 0)
                begin
                    $display("%0t: unexpected result gray %0d colour %h last %b",
                             $time, m_tdata[7:0], m_tdata[39:8], m_tlast);
                    failures++;
                end
                else
                begin
                    want = reduced_expected.pop_front();
                    if (m_tdata[7:0] !== want.gray)
                    begin
                        $display("%0t: gray_out expected %0d actual %0d",
                                 $time, want.gray, m_tdata[7:0]);
                        failures++;
                    end
                    if (m_tdata[39:8] !== want.colour)
                    begin
                        $display("%0t: color_out expected %h actual %h",
                                 $time, want.colour, m_tdata[39:8]);
                        failures++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last_pixel expected %b actual %b",
                                 $time, want.last, m_tlast);
                        failures++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("minimap_two_by_two_reducer regression: fail");
            $finish;
        end
    end

    // One configuration transaction; the model follows on acceptance.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, value);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every pixel is taken and every result has come, then lets the block settle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (!(pixel_queue.size() == 0 && !s_tvalid && reduced_expected.size() == 0));
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure_level(input int w, input int h, input int colour);
        wait_drained();
        write_register(CFG_SOURCE_WIDTH, CFG_DATA_W'(w));
        write_register(CFG_SOURCE_HEIGHT, CFG_DATA_W'(h));
        write_register(CFG_COLOR_ENABLE, CFG_DATA_W'(colour));
        @(negedge clk);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        sender_idle_pct = (mode == IDLE_SENDER) ? 47 : (mode == IDLE_BOTH) ? 22 : 0;
        receiver_idle_pct = (mode == IDLE_RECEIVER) ? 47 : (mode == IDLE_BOTH) ? 22 : 0;
    endtask

    // One phase of random pixels at a given level size and idling pattern.
    task automatic run_phase(input int w, input int h, input int colour, input int count,
                             input idle_mode_t mode, input bit long_stall,
                             input bit mid_pause);
        int first;
        configure_level(w, h, colour);
        set_idling(mode);
        if (long_stall)
            hold_requests++;
        first = mid_pause ? count / 2 : count;
        repeat (first) add_pixel(random_pixel());
        if (mid_pause)
        begin
            // Sender waits here until the block has given every result so far.
            wait_drained();
            @(negedge clk);
            repeat (count - first) add_pixel(random_pixel());
        end
    endtask

    initial
    begin : stimulus
        int w;
        int h;
        level_width = 8'(SOURCE_WIDTH_DEFAULT);
        level_height = 13'(SOURCE_HEIGHT_DEFAULT);
        colour_on = 1'b1;
        restart_level();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Three by three level: clipped right column, lone bottom row, single corner pixel.
        configure_level(3, 3, 1);
        add_pixel('{colour: 32'h0000_0000, gray: 8'd0});
        add_pixel('{colour: COLOR_NONE, gray: GRAY_BLANK});
        add_pixel('{colour: 32'hff00_ff00, gray: 8'd254});
        add_pixel('{colour: COLOR_NONE, gray: GRAY_BLANK});
        add_pixel('{colour: 32'h1234_5678, gray: GRAY_BLANK});
        add_pixel('{colour: COLOR_NONE, gray: 8'd128});
        add_pixel('{colour: COLOR_NONE, gray: GRAY_BLANK});
        add_pixel('{colour: COLOR_NONE, gray: GRAY_BLANK});
        add_pixel('{colour: 32'hffff_fffe, gray: 8'd1});

        // One by one level, two frames back to back.
        configure_level(1, 1, 1);
        add_pixel('{colour: COLOR_NONE, gray: GRAY_BLANK});
        add_pixel('{colour: 32'h8080_8080, gray: 8'd211});

        // Single-row level of even width: every block is a lone pair.
        configure_level(2, 1, 1);
        add_pixel('{colour: COLOR_NONE, gray: GRAY_BLANK});
        add_pixel('{colour: COLOR_NONE, gray: GRAY_BLANK});
        add_pixel('{colour: 32'hffff_ffff, gray: 8'd0});
        add_pixel('{colour: 32'h00ff_ffff, gray: 8'd255});

        // Random phases; out-of-range sizes saturate.
        run_phase(5, 7, 1, 105, IDLE_NONE, 1'b0, 1'b0);
        run_phase(0, 9, 0, 27, IDLE_SENDER, 1'b0, 1'b0);
        run_phase(255, 8191, 1, 400, IDLE_NONE, 1'b1, 1'b0);
        run_phase(16, 6, 1, 384, IDLE_RECEIVER, 1'b0, 1'b1);
        run_phase(7, 0, 1, 35, IDLE_BOTH, 1'b0, 1'b0);

        // A write to an index beyond the register list changes nothing.
        configure_level(9, 5, 0);
        write_register(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom()));
        @(negedge clk);
        set_idling(IDLE_BOTH);
        repeat (180) add_pixel(random_pixel());

        run_phase(128, 2, 1, 256, IDLE_SENDER, 1'b0, 1'b0);
        run_phase(2, 4096, 1, 100, IDLE_RECEIVER, 1'b0, 1'b0);
        repeat (3)
        begin
            w = $urandom_range(1, 20);
            h = $urandom_range(1, 10);
            run_phase(w, h, $urandom_range(0, 1), w * h,
                      idle_mode_t'($urandom_range(0, 3)), 1'b0, 1'b0);
        end

        wait_drained();
        if (failures == 0)
            $display("minimap_two_by_two_reducer regression: pass");
        else
            $display("minimap_two_by_two_reducer regression: fail");
        $finish;
    end

endmodule
